>>> design/slg_pkg.sv
// Shared constants and types for the smoothed level gate.
// Fixed-point widths, register indexes, config and gate result structs.
// No dependencies.
package slg_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int LVL_W        = FRAC_BITS + 1;
  localparam int RAW_W        = FRAC_BITS + 2;
  localparam int SMOOTH_SHIFT = 16;
  localparam int TIME_W       = 32;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_INDEX_W  = 3;

  localparam logic [LVL_W-1:0] ONE        = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [LVL_W-1:0] SMOOTH_MIN = LVL_W'((1 << FRAC_BITS) / 100);

  localparam logic [LVL_W-1:0]  RST_SMOOTHING = LVL_W'((1 << FRAC_BITS) / 5);
  localparam logic [LVL_W-1:0]  RST_ON_TH     = LVL_W'(((1 << FRAC_BITS) * 3 + 2) / 5);
  localparam logic [LVL_W-1:0]  RST_OFF_TH    = LVL_W'(((1 << FRAC_BITS) * 2 + 2) / 5);

  localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ON_THRESH   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OFF_THRESH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS = 3'd4;

  typedef struct packed {
    logic [LVL_W-1:0]  smoothing;
    logic [LVL_W-1:0]  on_threshold;
    logic [LVL_W-1:0]  off_threshold;
    logic [LVL_W-1:0]  deadband;
    logic [TIME_W-1:0] debounce_ms;
  } slg_cfg_t;

  typedef struct packed {
    logic active;
    logic pressed;
    logic released;
  } slg_gate_res_t;

endpackage

>>> design/slg_cfg_regs.sv
// Configuration register file for the smoothed level gate.
// Write-only; smoothing writes are clamped. Depends on slg_pkg.
module slg_cfg_regs
  import slg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output slg_cfg_t               cfg
);

  logic [LVL_W-1:0] wdata_lvl;
  logic [LVL_W-1:0] smoothing_clamped;

  assign wdata_lvl = cfg_wdata[LVL_W-1:0];

  always_comb begin
    if (wdata_lvl < SMOOTH_MIN) begin
      smoothing_clamped = SMOOTH_MIN;
    end else if (wdata_lvl > ONE) begin
      smoothing_clamped = ONE;
    end else begin
      smoothing_clamped = wdata_lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.smoothing     <= RST_SMOOTHING;
      cfg.on_threshold  <= RST_ON_TH;
      cfg.off_threshold <= RST_OFF_TH;
      cfg.deadband      <= '0;
      cfg.debounce_ms   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SMOOTHING:   cfg.smoothing     <= smoothing_clamped;
        REG_ON_THRESH:   cfg.on_threshold  <= wdata_lvl;
        REG_OFF_THRESH:  cfg.off_threshold <= wdata_lvl;
        REG_DEADBAND:    cfg.deadband      <= wdata_lvl;
        REG_DEBOUNCE_MS: cfg.debounce_ms   <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> design/slg_filter.sv
// Level path: input clamp, EMA step with rounding, deadband on the reported level.
// Holds filter state, updated on each item. Depends on slg_pkg.
module slg_filter
  import slg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [RAW_W-1:0] raw_level,
  input  slg_cfg_t         cfg,
  output logic [LVL_W-1:0] level
);

  localparam int PROD_W = 2 * LVL_W;

  logic               started;
  logic [LVL_W-1:0]   smoothed;
  logic [LVL_W-1:0]   reported;
  logic [LVL_W-1:0]   smoothed_next;
  logic [LVL_W-1:0]   reported_next;

  logic [LVL_W-1:0]   x;
  logic signed [LVL_W:0]   diff;
  logic [LVL_W-1:0]   mag;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W:0]    prod_rnd;
  logic [LVL_W-1:0]   step;
  logic signed [LVL_W+1:0] sum;
  logic [LVL_W-1:0]   ema;
  logic [LVL_W-1:0]   gap;

  always_comb begin
    if (raw_level[RAW_W-1]) begin
      x = '0;
    end else if (raw_level[RAW_W-2:0] > ONE) begin
      x = ONE;
    end else begin
      x = raw_level[LVL_W-1:0];
    end
  end

  assign diff     = $signed({1'b0, x}) - $signed({1'b0, smoothed});
  assign mag      = diff[LVL_W] ? LVL_W'(-diff) : diff[LVL_W-1:0];
  assign prod     = mag * cfg.smoothing;
  assign prod_rnd = {1'b0, prod} + (PROD_W+1)'(1 << (SMOOTH_SHIFT - 1));
  assign step     = prod_rnd[SMOOTH_SHIFT +: LVL_W];

  always_comb begin
    if (diff[LVL_W]) begin
      sum = $signed({2'b00, smoothed}) - $signed({2'b00, step});
    end else begin
      sum = $signed({2'b00, smoothed}) + $signed({2'b00, step});
    end
    if (sum[LVL_W+1]) begin
      ema = '0;
    end else if (sum[LVL_W:0] > {1'b0, ONE}) begin
      ema = ONE;
    end else begin
      ema = sum[LVL_W-1:0];
    end
    gap = (ema >= reported) ? (ema - reported) : (reported - ema);

    if (!started) begin
      smoothed_next = x;
      reported_next = x;
    end else begin
      smoothed_next = ema;
      reported_next = (gap >= cfg.deadband) ? ema : reported;
    end
  end

  assign level = reported_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      started  <= 1'b0;
      smoothed <= '0;
      reported <= '0;
    end else if (en) begin
      started  <= 1'b1;
      smoothed <= smoothed_next;
      reported <= reported_next;
    end
  end

endmodule

>>> design/slg_gate.sv
// Gate path: hysteresis or raw flag selects the wanted state, then debounce.
// Holds gate and candidate state, updated on each item. Depends on slg_pkg.
module slg_gate
  import slg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              op,
  input  logic              raw_on,
  input  logic [LVL_W-1:0]  level,
  input  logic [TIME_W-1:0] now_ms,
  input  slg_cfg_t          cfg,
  output slg_gate_res_t     res
);

  logic              gate_active;
  logic              cand_state;
  logic [TIME_W-1:0] cand_time;
  logic              want;
  logic              held;
  logic              next_active;

  always_comb begin
    if (op) begin
      want = raw_on;
    end else if (gate_active) begin
      want = level > cfg.off_threshold;
    end else begin
      want = level > cfg.on_threshold;
    end
  end

  // A fresh candidate has zero elapsed time, so only a zero hold passes it.
  assign held = (now_ms - cand_time) >= cfg.debounce_ms;

  always_comb begin
    if (want != cand_state) begin
      next_active = (cfg.debounce_ms == '0) ? want : gate_active;
    end else begin
      next_active = held ? cand_state : gate_active;
    end
  end

  assign res.active   = next_active;
  assign res.pressed  = next_active && !gate_active;
  assign res.released = !next_active && gate_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_active <= 1'b0;
      cand_state  <= 1'b0;
      cand_time   <= '0;
    end else if (en) begin
      gate_active <= next_active;
      if (want != cand_state) begin
        cand_state <= want;
        cand_time  <= now_ms;
      end
    end
  end

endmodule

>>> design/smoothed_level_gate.sv
// Smoothed level gate: EMA level meter with a hysteresis/debounced on-off gate.
// Top level: input register, level and gate paths, result register.
// Depends on slg_pkg, slg_cfg_regs, slg_filter, slg_gate.
//
// Takes one sample item per cycle while the output side does not stall and
// returns exactly one result item per sample. An input register and a result
// register bracket the combinational work: one 17x17 multiply for the EMA step,
// rounding, clamp, deadband compare, threshold compare and debounce decision,
// with all state updated as the item moves into the result register. A stall
// on the output holds the whole pipe; s_tready follows m_tready and free slots.
// The user must write configuration through cfg_we/cfg_index/cfg_wdata while
// no item is in flight; the block does not enforce this.
module smoothed_level_gate
  import slg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // raw_level[17:0], raw_on[18], sample_valid[19], now_ms[51:20], zero fill
  input  logic [55:0]            s_tdata,
  // op[0]
  input  logic [0:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // valid_out[0], level[17:1], active[18], pressed[19], released[20], zero fill
  output logic [23:0]            m_tdata
);

  slg_cfg_t          cfg;

  logic              in_valid;
  logic              in_op;
  logic [RAW_W-1:0]  in_raw_level;
  logic              in_raw_on;
  logic              in_sample_valid;
  logic [TIME_W-1:0] in_now_ms;

  logic              advance;
  logic              fire;
  logic [LVL_W-1:0]  level;
  slg_gate_res_t     gate_res;

  logic              out_valid_out;
  logic [LVL_W-1:0]  out_level;
  slg_gate_res_t     out_gate;

  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  slg_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  slg_filter u_filter (
    .clk       (clk),
    .rst       (rst),
    .en        (fire),
    .raw_level (in_raw_level),
    .cfg       (cfg),
    .level     (level)
  );

  slg_gate u_gate (
    .clk    (clk),
    .rst    (rst),
    .en     (fire),
    .op     (in_op),
    .raw_on (in_raw_on),
    .level  (level),
    .now_ms (in_now_ms),
    .cfg    (cfg),
    .res    (gate_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op           <= s_tuser[0];
      in_raw_level    <= s_tdata[17:0];
      in_raw_on       <= s_tdata[18];
      in_sample_valid <= s_tdata[19];
      in_now_ms       <= s_tdata[51:20];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_valid_out <= in_sample_valid;
      out_level     <= level;
      out_gate      <= gate_res;
    end
  end

  assign m_tdata = {3'b000, out_gate.released, out_gate.pressed, out_gate.active,
                    out_level, out_valid_out};

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_level <= ONE))
    else $error("reported level above full scale");

  a_pressed_active: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!out_gate.pressed || out_gate.active) &&
                 (!out_gate.released || !out_gate.active))
    else $error("gate edge disagrees with active state");

  a_smoothing_clamp: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (cfg.smoothing >= SMOOTH_MIN) && (cfg.smoothing <= ONE))
    else $error("smoothing coefficient outside clamp");

  a_edge_follows: assert property (@(posedge clk) disable iff (rst)
    fire && gate_res.pressed |=> m_tvalid && out_gate.active)
    else $error("pressed item lost on the way out");

endmodule

>>> test/gate_result_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the smoothed level gate: follows register writes and both
// item streams, predicts every result item and compares it field by field.
// Depends on slg_pkg.
module gate_result_checker
  import slg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  // raw_level[17:0], raw_on[18], sample_valid[19], now_ms[51:20], zero fill
  input  logic [55:0]            s_tdata,
  // op[0]
  input  logic [0:0]             s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  // valid_out[0], level[17:1], active[18], pressed[19], released[20], zero fill
  input  logic [23:0]            m_tdata,
  output int                     fail_count,
  output int                     results_due
);

  localparam int     ONE_I      = 1 << FRAC_BITS;
  localparam longint ROUND_HALF = longint'(1) << (SMOOTH_SHIFT - 1);

  typedef struct packed {
    logic             vld;
    logic [LVL_W-1:0] level;
    logic             active;
    logic             pressed;
    logic             released;
  } gate_result_t;

  // register copy
  logic [LVL_W-1:0]  smoothing_r;
  logic [LVL_W-1:0]  on_r;
  logic [LVL_W-1:0]  off_r;
  logic [LVL_W-1:0]  dead_r;
  logic [TIME_W-1:0] debounce_r;

  // filter and gate state
  logic              started_q;
  int                smooth_q;
  int                shown_q;
  logic              gate_q;
  logic              cand_q;
  logic [TIME_W-1:0] cand_t_q;

  gate_result_t expected_gates[$];
  int fails = 0;
  int due = 0;
  int reported = 0;

  assign fail_count  = fails;
  assign results_due = due;

  function automatic gate_result_t next_gate_result(input logic bool_mode,
                                                    input logic signed [RAW_W-1:0] raw,
                                                    input logic raw_on,
                                                    input logic vld,
                                                    input logic [TIME_W-1:0] now);
    int x;
    int diff;
    int mag;
    int gap;
    longint step;
    logic want;
    logic nxt;
    logic [TIME_W-1:0] held;
    gate_result_t r;
    x = raw;
    if (x < 0) x = 0;
    else if (x > ONE_I) x = ONE_I;
    if (!started_q) begin
      started_q = 1'b1;
      smooth_q  = x;
      shown_q   = x;
    end else begin
      diff = x - smooth_q;
      mag  = (diff < 0) ? -diff : diff;
      // magnitude rounded half away from zero, sign restored after
      step = (longint'(mag) * longint'(smoothing_r) + ROUND_HALF) >>> SMOOTH_SHIFT;
      smooth_q += (diff < 0) ? -int'(step) : int'(step);
      if (smooth_q < 0) smooth_q = 0;
      if (smooth_q > ONE_I) smooth_q = ONE_I;
      gap = smooth_q - shown_q;
      if (gap < 0) gap = -gap;
      if (gap >= int'(dead_r)) shown_q = smooth_q;
    end
    if (bool_mode) want = raw_on;
    else if (gate_q) want = shown_q > int'(off_r);
    else want = shown_q > int'(on_r);
    if (want != cand_q) begin
      cand_q   = want;
      cand_t_q = now;
    end
    held = now - cand_t_q;
    nxt = (held >= debounce_r) ? cand_q : gate_q;
    r.vld      = vld;
    r.level    = LVL_W'(shown_q);
    r.active   = nxt;
    r.pressed  = nxt && !gate_q;
    r.released = !nxt && gate_q;
    gate_q = nxt;
    return r;
  endfunction

  task automatic check_field(input string fname, input longint want, input longint got,
                             inout int errs);
    if (want != got) begin
      errs++;
      if (reported < 10)
        $display("%0t: %s mismatch, expected %0h got %0h", $realtime, fname, want, got);
      reported++;
    end
  endtask

  always @(posedge clk) begin
    gate_result_t want_r;
    gate_result_t got_r;
    logic [LVL_W-1:0] v17;
    int errs;
    errs = 0;
    if (rst) begin
      smoothing_r = RST_SMOOTHING;
      on_r        = RST_ON_TH;
      off_r       = RST_OFF_TH;
      dead_r      = '0;
      debounce_r  = '0;
      started_q   = 1'b0;
      smooth_q    = 0;
      shown_q     = 0;
      gate_q      = 1'b0;
      cand_q      = 1'b0;
      cand_t_q    = '0;
      expected_gates.delete();
    end else begin
      if (cfg_we) begin
        v17 = cfg_wdata[LVL_W-1:0];
        case (cfg_index)
          REG_SMOOTHING: begin
            if (v17 < SMOOTH_MIN) v17 = SMOOTH_MIN;
            if (v17 > ONE) v17 = ONE;
            smoothing_r = v17;
          end
          REG_ON_THRESH:   on_r = v17;
          REG_OFF_THRESH:  off_r = v17;
          REG_DEADBAND:    dead_r = v17;
          REG_DEBOUNCE_MS: debounce_r = cfg_wdata[TIME_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got_r.vld      = m_tdata[0];
        got_r.level    = m_tdata[LVL_W:1];
        got_r.active   = m_tdata[LVL_W+1];
        got_r.pressed  = m_tdata[LVL_W+2];
        got_r.released = m_tdata[LVL_W+3];
        if (expected_gates.size() == 0) begin
          errs++;
          if (reported < 10)
            $display("%0t: result item %h with nothing expected", $realtime, m_tdata);
          reported++;
        end else begin
          want_r = expected_gates.pop_front();
          check_field("valid_out", want_r.vld, got_r.vld, errs);
          check_field("level", want_r.level, got_r.level, errs);
          check_field("active", want_r.active, got_r.active, errs);
          check_field("pressed", want_r.pressed, got_r.pressed, errs);
          check_field("released", want_r.released, got_r.released, errs);
        end
      end
      if (s_tvalid && s_tready)
        expected_gates.push_back(next_gate_result(s_tuser[0], s_tdata[RAW_W-1:0],
                                                  s_tdata[RAW_W], s_tdata[RAW_W+1],
                                                  s_tdata[RAW_W+2 +: TIME_W]));
    end
    due   <= expected_gates.size();
    fails <= fails + errs;
  end

endmodule

>>> test/tb_smoothed_level_gate.sv
`timescale 1ns / 100ps
// Testbench top for the smoothed level gate: clock, reset, register setup,
// directed and random samples, random stalls on both streams, verdict.
// Depends on slg_pkg, smoothed_level_gate and gate_result_checker.
module tb_smoothed_level_gate;
  import slg_pkg::*;

  localparam bit OP_LEVEL = 1'b0;
  localparam bit OP_BOOL  = 1'b1;
  localparam int SENDER   = 0;
  localparam int RECEIVER = 1;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 235;
  localparam logic signed [RAW_W-1:0] RAW_MIN = {1'b1, {(RAW_W-1){1'b0}}};
  localparam logic signed [RAW_W-1:0] RAW_MAX = {1'b0, {(RAW_W-1){1'b1}}};
  localparam logic [CFG_INDEX_W-1:0]  REG_PAST_END = REG_DEBOUNCE_MS + 1'b1;
  localparam logic [31:0] UPPER_JUNK = ~32'h0001_FFFF;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [55:0]            s_tdata = '0;
  logic [0:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [23:0]            m_tdata;

  int fail_count;
  int results_due;
  int idle_cycles = 0;
  bit calm[2] = '{1'b0, 1'b0};
  logic [TIME_W-1:0] clock_ms = '0;

  smoothed_level_gate i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  gate_result_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // calm stretches: no idling at all on that side
  function automatic int draw_gap(input int side);
    if ($urandom_range(0, 47) == 0) calm[side] = !calm[side];
    return calm[side] ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic send_sample(input bit op, input logic signed [RAW_W-1:0] raw,
                             input bit raw_on, input bit vld,
                             input logic [TIME_W-1:0] now);
    int gap;
    gap = draw_gap(SENDER);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, now, vld, raw_on, raw};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [31:0] sm, on_v, off_v, db, deb);
    wait_drained();
    write_reg(REG_SMOOTHING, sm);
    write_reg(REG_ON_THRESH, on_v);
    write_reg(REG_OFF_THRESH, off_v);
    write_reg(REG_DEADBAND, db);
    write_reg(REG_DEBOUNCE_MS, deb);
    write_reg(CFG_INDEX_W'(REG_PAST_END + $urandom_range(0, 2)), $urandom());
    cfg_we <= 1'b0;
  endtask

  initial begin
    int gap;
    wait (!rst);
    forever begin
      gap = draw_gap(RECEIVER);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int target;
    int r;
    bit op;
    bit raw_on;
    logic [31:0] sm, on_v, off_v, db, deb;
    target = int'(ONE) / 2;
    op = OP_LEVEL;
    raw_on = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: first sample loads, clamps, climb over on, fall under off
    send_sample(OP_LEVEL, RAW_MIN, 1'b0, 1'b1, 32'd0);
    send_sample(OP_LEVEL, RAW_MAX, 1'b1, 1'b0, 32'd1);
    repeat (5) send_sample(OP_LEVEL, RAW_W'(ONE), 1'b0, 1'b1, 32'd2);
    repeat (4) send_sample(OP_LEVEL, '0, 1'b1, 1'b1, 32'd3);
    send_sample(OP_BOOL, RAW_W'(1), 1'b1, 1'b0, 32'hFFFF_FFFF);
    send_sample(OP_BOOL, RAW_W'(ONE - 1), 1'b0, 1'b1, 32'd0);

    // smoothing clamped to one, zero thresholds
    program_regs(32'hFFFF_FFFF, '0, '0, '0, '0);
    send_sample(OP_LEVEL, RAW_W'(1), 1'b0, 1'b1, 32'd10);
    send_sample(OP_LEVEL, '0, 1'b1, 1'b0, 32'd11);
    send_sample(OP_LEVEL, RAW_W'(ONE), 1'b0, 1'b1, 32'd12);

    // minimum smoothing, unreachable on level, full deadband, longest hold
    program_regs('0, 32'(ONE), 32'h0001_FFFF, 32'(ONE), 32'hFFFF_FFFF);
    send_sample(OP_BOOL, RAW_W'(ONE), 1'b1, 1'b1, 32'd5);
    send_sample(OP_BOOL, RAW_W'(ONE), 1'b1, 1'b1, 32'd4);
    send_sample(OP_LEVEL, RAW_MAX, 1'b0, 1'b0, 32'd4);
    send_sample(OP_LEVEL, RAW_MAX, 1'b1, 1'b1, 32'd3);

    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 4))
        0: sm = $urandom();
        1: sm = 32'(SMOOTH_MIN);
        2: sm = 32'(ONE);
        default: sm = $urandom_range(SMOOTH_MIN, ONE);
      endcase
      on_v  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h1FFFF)
                                          : $urandom_range(16000, 60000);
      off_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h1FFFF)
                                          : $urandom_range(0, on_v);
      db    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ONE)
                                          : $urandom_range(0, 2000);
      if ($urandom_range(0, 1)) on_v |= $urandom() & UPPER_JUNK;
      if ($urandom_range(0, 1)) db |= $urandom() & UPPER_JUNK;
      case ($urandom_range(0, 5))
        0: deb = '0;
        1: deb = $urandom();
        2: deb = 32'hFFFF_FFFF;
        default: deb = $urandom_range(1, 40);
      endcase
      program_regs(sm, on_v, off_v, db, deb);
      if ($urandom_range(0, 2) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 600);

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 29) == 0) target = $urandom_range(0, ONE);
        if ($urandom_range(0, 39) == 0) op = !op;
        if ($urandom_range(0, 7) == 0) raw_on = !raw_on;
        if ($urandom_range(0, 49) == 0) clock_ms = $urandom();
        else clock_ms += $urandom_range(0, 15);
        case ($urandom_range(0, 19))
          0: r = $urandom();
          1: r = $urandom_range(0, 1) ? RAW_MIN : RAW_MAX;
          default: r = target + int'($urandom_range(0, 8000)) - 4000;
        endcase
        send_sample(op, r[RAW_W-1:0], raw_on, 1'($urandom_range(0, 1)), clock_ms);
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/slg_pkg.sv
design/slg_cfg_regs.sv
design/slg_filter.sv
design/slg_gate.sv
design/smoothed_level_gate.sv
test/gate_result_checker.sv
test/tb_smoothed_level_gate.sv
